/* rtl/core/rrts_pkg.sv */
package rrts_pkg;

	localparam int DEFAULT_SLOTS = 64;
	localparam int KEY_W         = 64;
	localparam int SLOT_W        = 6;
	localparam int COUNT_W       = 7;

	// operation codes
	localparam logic [2:0] FN_CREATE   = 3'd0;
	localparam logic [2:0] FN_SCHEDULE = 3'd1;
	localparam logic [2:0] FN_WAIT     = 3'd2;
	localparam logic [2:0] FN_WAKE     = 3'd3;
	localparam logic [2:0] FN_REMOVE   = 3'd4;

	// slot states
	localparam logic [1:0] SS_EMPTY    = 2'd0;
	localparam logic [1:0] SS_WAIT     = 2'd1;
	localparam logic [1:0] SS_RUNNABLE = 2'd2;
	localparam logic [1:0] SS_RUNNING  = 2'd3;

	// wait reasons
	localparam logic [1:0] RS_TIME = 2'd0;
	localparam logic [1:0] RS_COND = 2'd1;
	localparam logic [1:0] RS_MSG  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NO_FREE    = 2'd1;
	localparam logic [1:0] STAT_IDLE       = 2'd2;
	localparam logic [1:0] STAT_SLOT_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic [SLOT_W-1:0]  slot_in;
		logic               use_current;
		logic [1:0]         reason_in;
		logic [KEY_W-1:0]   wait_key;
		logic [KEY_W-1:0]   now_ns;
		logic [COUNT_W-1:0] max_wake;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot_out;
		logic [COUNT_W-1:0] woken_count;
	} rsp_t;

	// one task table entry
	typedef struct packed {
		logic [1:0]       st;
		logic [1:0]       rs;
		logic [KEY_W-1:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_DEMOTE_RD,
		SQ_DEMOTE_WR,
		SQ_SCAN,
		SQ_PROBE,
		SQ_APPLY,
		SQ_DONE
	} seq_t;

endpackage

/* rtl/core/rrts_ram.sv */
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/round_robin_task_scheduler.sv */
// Create and wake scan the table; schedule first demotes the running task, then
// scans; wait and remove probe one slot and then apply; unknown operations go straight
// to the result. During a scan one slot table entry is read per cycle from a task RAM
// with one read and one write port, so a full scan over all slots bounds throughput.
// One transaction at a time; a new one is taken while the last result waits.
// arst_n clears the control state, then a clearing pass empties every slot while
// req_stall stays high.
module round_robin_task_scheduler import rrts_pkg::*; #(
	parameter int SLOTS = DEFAULT_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(SLOTS);
	localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);

	seq_t sq_q, sq_d;

	req_t               req_q;
	logic [IW-1:0]      cur_q;
	logic               cur_valid_q;
	logic [IW-1:0]      last_q;
	logic [IW-1:0]      tgt_q;
	logic               tgt_bad_q;
	logic [IW-1:0]      clr_addr_q;
	logic [IW-1:0]      scan_addr_q;
	logic [CW-1:0]      issue_cnt_q;
	logic               ev_valid_s1;
	logic [IW-1:0]      ev_addr_s1;
	logic               ev_last_s1;
	logic [COUNT_W-1:0] limit_q;
	logic [CW-1:0]      woken_q;
	logic [1:0]         status_q;
	logic [IW-1:0]      pick_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [IW-1:0] ram_raddr;
	entry_t        ram_rdata;

	logic          req_accept;
	logic          slot_ok;
	logic [IW-1:0] slot_idx;
	logic [IW-1:0] start_idx;
	logic          issue_en;
	logic          create_hit;
	logic          sched_release;
	logic          sched_hit;
	logic          wake_match;
	logic          scan_hit;
	logic          scan_end;
	logic          probe_bad;
	logic          rsp_load;

	rrts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall  = (sq_q != SQ_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// decode the incoming target slot
	assign slot_ok  = (32'(req.slot_in) < 32'(SLOTS));
	assign slot_idx = IW'(req.slot_in);

	// pick the first slot each scan visits
	always_comb begin
		case (req.func)
			FN_SCHEDULE: start_idx = (last_q == LAST_IDX) ? '0 : last_q + 1'b1;
			FN_WAKE:     start_idx = cur_valid_q ? cur_q : '0;
			default:     start_idx = '0;
		endcase
	end

	// evaluate the entry read back during a scan or probe
	assign issue_en      = (sq_q == SQ_SCAN) && (issue_cnt_q != CNT_FULL);
	assign create_hit    = (ram_rdata.st == SS_EMPTY);
	assign sched_release = (ram_rdata.st == SS_WAIT) && (ram_rdata.rs == RS_TIME) &&
		(ram_rdata.key <= req_q.now_ns);
	assign sched_hit     = (ram_rdata.st == SS_RUNNABLE) || sched_release;
	assign wake_match    = (ram_rdata.st == SS_WAIT) && (ram_rdata.rs == req_q.reason_in) &&
		(ram_rdata.key == req_q.wait_key) &&
		(((req_q.reason_in == RS_COND) && (limit_q != '0)) || (req_q.reason_in == RS_MSG));
	assign probe_bad     = tgt_bad_q || (ram_rdata.st == SS_EMPTY);

	always_comb begin
		case (req_q.func)
			FN_CREATE:   scan_hit = create_hit;
			FN_SCHEDULE: scan_hit = sched_hit;
			default:     scan_hit = 1'b0;
		endcase
	end

	assign scan_end = ev_valid_s1 && (scan_hit || ev_last_s1);
	assign rsp_load = (sq_q == SQ_DONE) && (!rsp_valid_q || !rsp_stall);

	// next state
	always_comb begin
		sq_d = sq_q;
		case (sq_q)
			SQ_CLEAR: begin
				if (clr_addr_q == LAST_IDX) begin
					sq_d = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				if (req_accept) begin
					case (req.func)
						FN_CREATE:   sq_d = SQ_SCAN;
						FN_WAKE:     sq_d = SQ_SCAN;
						FN_SCHEDULE: sq_d = SQ_DEMOTE_RD;
						FN_WAIT:     sq_d = SQ_PROBE;
						FN_REMOVE:   sq_d = SQ_PROBE;
						default:     sq_d = SQ_DONE;
					endcase
				end
			end
			SQ_DEMOTE_RD: sq_d = SQ_DEMOTE_WR;
			SQ_DEMOTE_WR: sq_d = SQ_SCAN;
			SQ_SCAN: begin
				if (scan_end) begin
					sq_d = SQ_DONE;
				end
			end
			SQ_PROBE: sq_d = SQ_APPLY;
			SQ_APPLY: sq_d = SQ_DONE;
			SQ_DONE: begin
				if (rsp_load) begin
					sq_d = SQ_IDLE;
				end
			end
			default: sq_d = SQ_IDLE;
		endcase
	end

	// table port controls
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = ev_addr_s1;
		ram_wdata    = ram_rdata;
		ram_raddr    = scan_addr_q;
		case (sq_q)
			SQ_CLEAR: begin
				ram_we       = 1'b1;
				ram_waddr    = clr_addr_q;
				ram_wdata    = '0;
				ram_wdata.st = SS_EMPTY;
			end
			SQ_DEMOTE_RD: ram_raddr = cur_q;
			SQ_DEMOTE_WR: begin
				ram_waddr = cur_q;
				if (cur_valid_q && (ram_rdata.st == SS_RUNNING)) begin
					ram_we       = 1'b1;
					ram_wdata.st = SS_RUNNABLE;
				end
			end
			SQ_SCAN: begin
				if (ev_valid_s1) begin
					case (req_q.func)
						FN_CREATE: begin
							ram_we       = create_hit;
							ram_wdata.st = SS_RUNNABLE;
						end
						FN_SCHEDULE: begin
							ram_we       = sched_hit;
							ram_wdata.st = SS_RUNNING;
						end
						FN_WAKE: begin
							ram_we       = wake_match;
							ram_wdata.st = SS_RUNNABLE;
						end
						default: ram_we = 1'b0;
					endcase
				end
			end
			SQ_PROBE: ram_raddr = tgt_q;
			SQ_APPLY: begin
				ram_waddr = tgt_q;
				ram_we    = !probe_bad;
				if (req_q.func == FN_WAIT) begin
					ram_wdata.st  = SS_WAIT;
					ram_wdata.rs  = req_q.reason_in;
					ram_wdata.key = req_q.wait_key;
				end else begin
					ram_wdata.st = SS_EMPTY;
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q        <= SQ_CLEAR;
			clr_addr_q  <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			last_q      <= LAST_IDX;
			ev_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			sq_q        <= sq_d;
			ev_valid_s1 <= issue_en;
			if (sq_q == SQ_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			// track the running task
			if ((sq_q == SQ_SCAN) && ev_valid_s1 && (req_q.func == FN_SCHEDULE)) begin
				if (sched_hit) begin
					cur_q       <= ev_addr_s1;
					cur_valid_q <= 1'b1;
					last_q      <= ev_addr_s1;
				end else if (ev_last_s1) begin
					cur_valid_q <= 1'b0;
				end
			end
			if ((sq_q == SQ_APPLY) && (req_q.func == FN_REMOVE) && !probe_bad &&
				cur_valid_q && (cur_q == tgt_q)) begin
				cur_valid_q <= 1'b0;
			end
			// hand over the result transaction
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q       <= req;
			limit_q     <= req.max_wake;
			woken_q     <= '0;
			status_q    <= STAT_OK;
			pick_q      <= '0;
			issue_cnt_q <= '0;
			scan_addr_q <= start_idx;
			if ((req.func == FN_WAIT) && req.use_current) begin
				tgt_q     <= cur_q;
				tgt_bad_q <= !cur_valid_q;
			end else begin
				tgt_q     <= slot_idx;
				tgt_bad_q <= !slot_ok;
			end
		end
		// advance the read side of the scan
		if (issue_en) begin
			scan_addr_q <= (scan_addr_q == LAST_IDX) ? '0 : scan_addr_q + 1'b1;
			issue_cnt_q <= issue_cnt_q + 1'b1;
			ev_addr_s1  <= scan_addr_q;
			ev_last_s1  <= (issue_cnt_q == CNT_LAST);
		end
		// gather results from the evaluated entry
		if ((sq_q == SQ_SCAN) && ev_valid_s1) begin
			case (req_q.func)
				FN_CREATE: begin
					if (create_hit) begin
						pick_q <= ev_addr_s1;
					end else if (ev_last_s1) begin
						status_q <= STAT_NO_FREE;
					end
				end
				FN_SCHEDULE: begin
					if (sched_release) begin
						woken_q <= woken_q + 1'b1;
					end
					if (sched_hit) begin
						pick_q <= ev_addr_s1;
					end else if (ev_last_s1) begin
						status_q <= STAT_IDLE;
					end
				end
				FN_WAKE: begin
					if (wake_match) begin
						woken_q <= woken_q + 1'b1;
						if (req_q.reason_in == RS_COND) begin
							limit_q <= limit_q - 1'b1;
						end
					end
				end
				default: status_q <= status_q;
			endcase
		end
		if ((sq_q == SQ_APPLY) && probe_bad) begin
			status_q <= STAT_SLOT_EMPTY;
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.slot_out    <= SLOT_W'(pick_q);
			rsp_q.woken_count <= COUNT_W'(woken_q);
		end
	end

endmodule

/* test/round_robin_task_scheduler_tb.sv */
`timescale 1ns / 1ps

module round_robin_task_scheduler_tb;
	import rrts_pkg::*;

	localparam int SLOTS        = DEFAULT_SLOTS;
	localparam int RANDOM_ITEMS = 1430;
	localparam int STUCK_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		req_t item;
		bit   drain_first;
	} pend_t;

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req     = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// stimulus waiting to be offered, results waiting to be seen
	pend_t req_queue[$];
	rsp_t  pending_rsp[$];

	// shadow task table
	logic [1:0]         task_state[SLOTS];
	logic [1:0]         task_reason[SLOTS];
	logic [KEY_W-1:0]   task_key[SLOTS];
	logic [SLOT_W-1:0]  run_slot;
	logic               run_valid;
	int                 last_pick;

	int mismatches  = 0;
	int rsp_accepts = 0;
	int stuck_cycles = 0;
	int gap_left    = 0;
	int burst_left  = 0;
	int hold_left   = 0;
	int holds_done  = 0;
	int mode_left   = 0;
	int stall_mode  = 0;
	int stall_phase = 0;

	round_robin_task_scheduler #(.SLOTS(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d (after %0d results)",
			what, got, want, rsp_accepts);
		mismatches++;
	endtask

	// Apply one operation to the shadow table and return its result
	function automatic rsp_t table_step(input req_t r);
		rsp_t               res;
		int                 s;
		int                 k;
		int                 start;
		logic [COUNT_W-1:0] woken;
		logic [COUNT_W-1:0] budget;
		logic [SLOT_W-1:0]  tgt;
		logic               found;
		res    = '0;
		woken  = '0;
		budget = r.max_wake;
		found  = 1'b0;
		case (r.func)
			FN_CREATE: begin
				res.status = STAT_NO_FREE;
				for (s = 0; s < SLOTS; s++) begin
					if (!found && task_state[s] == SS_EMPTY) begin
						task_state[s] = SS_RUNNABLE;
						res.status    = STAT_OK;
						res.slot_out  = SLOT_W'(s);
						found         = 1'b1;
					end
				end
			end
			FN_SCHEDULE: begin
				// demote the running task, then scan after the last pick
				if (run_valid && task_state[run_slot] == SS_RUNNING)
					task_state[run_slot] = SS_RUNNABLE;
				for (k = 1; k <= SLOTS; k++) begin
					if (!found) begin
						s = (last_pick + k) % SLOTS;
						if (task_state[s] == SS_WAIT && task_reason[s] == RS_TIME &&
							task_key[s] <= r.now_ns) begin
							task_state[s] = SS_RUNNABLE;
							woken++;
						end
						if (task_state[s] == SS_RUNNABLE) begin
							task_state[s] = SS_RUNNING;
							run_slot      = SLOT_W'(s);
							run_valid     = 1'b1;
							last_pick     = s;
							res.slot_out  = SLOT_W'(s);
							found         = 1'b1;
						end
					end
				end
				if (!found) begin
					run_valid  = 1'b0;
					res.status = STAT_IDLE;
				end
				res.woken_count = woken;
			end
			FN_WAIT: begin
				tgt = r.use_current ? run_slot : r.slot_in;
				if ((r.use_current && !run_valid) || task_state[tgt] == SS_EMPTY) begin
					res.status = STAT_SLOT_EMPTY;
				end else begin
					task_state[tgt]  = SS_WAIT;
					task_reason[tgt] = r.reason_in;
					task_key[tgt]    = r.wait_key;
				end
			end
			FN_WAKE: begin
				start = run_valid ? int'(run_slot) : 0;
				for (k = 0; k < SLOTS; k++) begin
					s = (start + k) % SLOTS;
					if (task_state[s] == SS_WAIT && task_reason[s] == r.reason_in &&
						task_key[s] == r.wait_key) begin
						if (r.reason_in == RS_COND) begin
							if (budget != 0) begin
								budget--;
								task_state[s] = SS_RUNNABLE;
								woken++;
							end
						end else if (r.reason_in == RS_MSG) begin
							task_state[s] = SS_RUNNABLE;
							woken++;
						end
					end
				end
				res.woken_count = woken;
			end
			FN_REMOVE: begin
				if (task_state[r.slot_in] == SS_EMPTY) begin
					res.status = STAT_SLOT_EMPTY;
				end else begin
					task_state[r.slot_in] = SS_EMPTY;
					if (run_valid && run_slot == r.slot_in)
						run_valid = 1'b0;
				end
			end
			default: res = '0;
		endcase
		return res;
	endfunction

	function automatic req_t make_req(input logic [2:0] fn, input int slot, input int use_cur,
		input logic [1:0] reason, input logic [KEY_W-1:0] key,
		input logic [KEY_W-1:0] now, input int maxw);
		req_t r;
		r.func        = fn;
		r.slot_in     = SLOT_W'(slot);
		r.use_current = (use_cur != 0);
		r.reason_in   = reason;
		r.wait_key    = key;
		r.now_ns      = now;
		r.max_wake    = COUNT_W'(maxw);
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// small pool so that wakes find matching waiters
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 64'd1;
			2: return '1;
			3: return 64'h5A5A_C3C3_0F0F_9696;
			4: return 64'h8000_0000_0000_0000;
			default: return rand_word();
		endcase
	endfunction

	function automatic logic [1:0] pick_reason(input bit time_common);
		int p;
		p = $urandom_range(0, 9);
		if (p < (time_common ? 4 : 1)) return RS_TIME;
		if (p < 6) return RS_COND;
		if (p < 9) return RS_MSG;
		return 2'd3;
	endfunction

	task automatic add_item(input req_t r, input bit drain);
		pend_t p;
		p.item        = r;
		p.drain_first = drain;
		req_queue.push_back(p);
	endtask

	// Offer queued transactions in bursts; predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (req_valid && !req_stall)
				pending_rsp.push_back(table_step(req));
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (req_queue.size() == 0 ||
					(req_queue[0].drain_first && pending_rsp.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					req       <= req_queue[0].item;
					req_valid <= 1'b1;
					req_queue.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end
				end
			end
		end
	end

	// Stall results on a changing pattern, with two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (holds_done < 2 && rsp_accepts >= 300 + holds_done * 600) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 200);
			end
			mode_left--;
			stall_phase++;
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 99) < 30);
				2: rsp_stall <= (stall_phase % 5 >= 3);
				default: rsp_stall <= ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_accepts++;
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with nothing pending, status", int'(rsp.status), -1);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.slot_out !== want.slot_out)
					report_mismatch("slot_out", int'(rsp.slot_out), int'(want.slot_out));
				if (rsp.woken_count !== want.woken_count)
					report_mismatch("woken_count", int'(rsp.woken_count),
						int'(want.woken_count));
			end
		end
	end

	// Count cycles without any transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		req_t             r;
		int               n;
		int               k;
		int               op;
		int               pick;
		int               total;
		int               phase_left;
		int               op_weight[6];
		logic [KEY_W-1:0] gen_now;

		// reset the shadow table
		for (k = 0; k < SLOTS; k++) begin
			task_state[k]  = SS_EMPTY;
			task_reason[k] = '0;
			task_key[k]    = '0;
		end
		run_slot   = '0;
		run_valid  = 1'b0;
		last_pick  = SLOTS - 1;
		phase_left = 0;
		gen_now    = 64'd1000;

		// directed: empty table, bad targets, each wait reason, limits, unknown codes
		add_item(make_req(FN_SCHEDULE, 0, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_WAKE, 0, 0, RS_COND, '0, '0, 64), 0);
		add_item(make_req(FN_WAIT, 5, 0, RS_COND, '1, '1, 0), 0);
		add_item(make_req(FN_REMOVE, 63, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_WAIT, 63, 1, RS_MSG, '0, '0, 127), 0);
		add_item(make_req(FN_CREATE, 0, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_CREATE, 63, 1, 2'd3, '1, '1, 127), 0);
		add_item(make_req(FN_CREATE, 0, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_SCHEDULE, 0, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_WAIT, 0, 1, RS_TIME, '1, '0, 0), 0);
		add_item(make_req(FN_WAIT, 1, 0, RS_COND, '1, '0, 0), 0);
		add_item(make_req(FN_WAIT, 2, 0, RS_MSG, '0, '0, 0), 0);
		add_item(make_req(FN_SCHEDULE, 0, 0, RS_TIME, '0, '1, 0), 0);
		add_item(make_req(FN_WAKE, 0, 0, RS_COND, '1, '0, 0), 0);
		add_item(make_req(FN_WAKE, 0, 0, RS_COND, '1, '0, 64), 0);
		add_item(make_req(FN_WAKE, 0, 0, RS_MSG, '0, '0, 0), 0);
		add_item(make_req(FN_WAIT, 1, 0, 2'd3, '0, '0, 0), 0);
		add_item(make_req(FN_WAKE, 0, 0, 2'd3, '0, '0, 64), 0);
		add_item(make_req(FN_WAIT, 2, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_WAKE, 0, 0, RS_TIME, '0, '0, 64), 0);
		add_item(make_req(FN_SCHEDULE, 0, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_REMOVE, 0, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(FN_REMOVE, 1, 0, RS_TIME, '0, '0, 0), 0);
		add_item(make_req(3'd5, 63, 1, 2'd3, '1, '1, 127), 0);
		add_item(make_req(3'd7, 0, 0, RS_TIME, '0, '0, 0), 0);

		// random: phases of shifting operation mix, one burst that fills the table
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				for (k = 0; k < 5; k++)
					op_weight[k] = $urandom_range(1, 10);
				op_weight[5] = 1;
				phase_left   = $urandom_range(100, 300);
			end
			phase_left--;
			total = 0;
			for (k = 0; k < 6; k++)
				total += op_weight[k];
			pick = $urandom_range(0, total - 1);
			op   = 0;
			while (pick >= op_weight[op]) begin
				pick -= op_weight[op];
				op++;
			end
			if (n >= 400 && n < 470)
				op = 0;

			r = make_req(3'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom_range(0, 1),
				2'($urandom_range(0, 3)), rand_word(), rand_word(), $urandom_range(0, 127));
			if ($urandom_range(0, 1) == 0)
				r.slot_in = SLOT_W'($urandom_range(0, 15));
			case (op)
				0: r.func = FN_CREATE;
				1: begin
					r.func  = FN_SCHEDULE;
					gen_now = gen_now + KEY_W'($urandom_range(0, 60));
					case ($urandom_range(0, 19))
						0: r.now_ns = rand_word();
						1: r.now_ns = '1;
						2: r.now_ns = '0;
						default: r.now_ns = gen_now;
					endcase
				end
				2: begin
					r.func        = FN_WAIT;
					r.use_current = ($urandom_range(0, 9) < 4);
					r.reason_in   = pick_reason(1'b1);
					if (r.reason_in == RS_TIME) begin
						case ($urandom_range(0, 7))
							0: r.wait_key = '0;
							1: r.wait_key = '1;
							2: r.wait_key = rand_word();
							default: r.wait_key = gen_now + KEY_W'($urandom_range(0, 200));
						endcase
					end else begin
						r.wait_key = pick_key();
					end
				end
				3: begin
					r.func      = FN_WAKE;
					r.reason_in = pick_reason(1'b0);
					r.wait_key  = pick_key();
					case ($urandom_range(0, 9))
						0: r.max_wake = '0;
						1: r.max_wake = COUNT_W'($urandom_range(0, 127));
						2: r.max_wake = COUNT_W'(64);
						default: r.max_wake = COUNT_W'($urandom_range(1, 4));
					endcase
				end
				4: r.func = FN_REMOVE;
				default: r.func = 3'($urandom_range(5, 7));
			endcase
			add_item(r, (n == 500 || n == 1100));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// let everything drain, then allow for late or extra results
		while (req_queue.size() != 0 || req_valid || pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch("results never arrived", 0, pending_rsp.size());

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/rrts_pkg.sv
rtl/core/rrts_ram.sv
rtl/core/round_robin_task_scheduler.sv
test/round_robin_task_scheduler_tb.sv
